/* rtl/core/s2d_pkg.sv */
`timescale 1ns / 1ps

package s2d_pkg;

	localparam int STORE_DEPTH  = 1024;
	localparam int MAX_RANK     = 4;
	localparam int INDEX_FIELDS = 4;
	localparam int RANK_LIMIT   = (MAX_RANK < INDEX_FIELDS) ? MAX_RANK : INDEX_FIELDS;

	localparam int ADDR_W    = $clog2(STORE_DEPTH);
	localparam int STEP_W    = (INDEX_FIELDS > 1) ? $clog2(INDEX_FIELDS) : 1;
	localparam int KIND_W    = 2;
	localparam int IDX_W     = 10;
	localparam int CELL_W    = 10;
	localparam int OFS_W     = 10;
	localparam int DIM_W     = 11;
	localparam int RANK_W    = 3;
	localparam int WORD_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int ENTRY_W   = WORD_W + 1;
	localparam int PROD_W    = ADDR_W + DIM_W + 1;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANK          = 3'd0,
		CFG_DIM_0         = 3'd1,
		CFG_DIM_1         = 3'd2,
		CFG_DIM_2         = 3'd3,
		CFG_DIM_3         = 3'd4,
		CFG_ELEMENT_WORDS = 3'd5,
		CFG_DEFAULT_BITS  = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_INDEX,
		ST_SCALE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  index_0;
		logic [IDX_W-1:0]  index_1;
		logic [IDX_W-1:0]  index_2;
		logic [IDX_W-1:0]  index_3;
		logic [WORD_W-1:0] value_bits;
		logic [IDX_W-1:0]  read_address;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_bits;
		logic [CELL_W-1:0] cell_address;
		logic              in_range;
	} rsp_t;

endpackage

/* rtl/core/s2d_ram.sv */
`timescale 1ns / 1ps

module s2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/sparse_to_dense_scatter_core.sv */
`timescale 1ns / 1ps
// Write request: ST_INDEX runs the rank's dimensions on one shared index multiplier,
//   one dimension a cycle; ST_SCALE writes the store, ST_EMIT loads the result when free.
// Read request: the registered read of the store RAM is taken in ST_READ, then ST_EMIT.
// Clear request: a sweep of the written flags one entry a cycle, then ST_EMIT; no new request until idle.
// Reset: asynchronous; a sweep of all STORE_DEPTH entries clears the flags, requests wait.
module sparse_to_dense_scatter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [s2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [s2d_pkg::WORD_W-1:0]     cfg_data,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  s2d_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output s2d_pkg::rsp_t                  rsp
);

	logic [s2d_pkg::RANK_W-1:0] rank_q;
	logic [s2d_pkg::DIM_W-1:0]  dim_size_q [s2d_pkg::INDEX_FIELDS];
	logic [s2d_pkg::DIM_W-1:0]  element_words_q;
	logic [s2d_pkg::WORD_W-1:0] default_bits_q;

	s2d_pkg::state_t state_q, state_d;
	logic                       init_q;
	logic [s2d_pkg::ADDR_W-1:0] sweep_q;
	logic [s2d_pkg::OFS_W-1:0]  offset_q;
	logic                       rsp_valid_q;
	s2d_pkg::rsp_t              rsp_q;
	s2d_pkg::rsp_t              res_q;

	logic [s2d_pkg::IDX_W-1:0]  idx_q [s2d_pkg::INDEX_FIELDS];
	logic [s2d_pkg::WORD_W-1:0] value_q;
	logic [s2d_pkg::STEP_W-1:0] step_q;
	logic [s2d_pkg::ADDR_W-1:0] lin_q;
	logic                       bad_q;

	logic                        accept;
	logic                        can_emit;
	logic                        load_out;
	logic                        sweep_last;
	logic [s2d_pkg::RANK_W-1:0]  eff_rank;
	logic                        last_step;
	logic [s2d_pkg::DIM_W-1:0]   ew_eff;
	logic [s2d_pkg::IDX_W-1:0]   cur_idx;
	logic [s2d_pkg::DIM_W-1:0]   cur_dim;
	logic [s2d_pkg::PROD_W-1:0]  lin_ext, dim_ext, idx_ext, prod;
	logic [s2d_pkg::PROD_W-1:0]  ew_ext, ofs_ext, scaled;
	logic                        idx_bad, lin_big, addr_ok;
	logic [s2d_pkg::OFS_W:0]     ofs_next;
	logic [s2d_pkg::OFS_W-1:0]   ofs_adv;
	logic                        rd_in_range;

	logic                         ram_we;
	logic [s2d_pkg::ADDR_W-1:0]   ram_waddr;
	logic [s2d_pkg::ENTRY_W-1:0]  ram_wdata;
	logic [s2d_pkg::ADDR_W-1:0]   ram_raddr;
	logic [s2d_pkg::ENTRY_W-1:0]  ram_rdata;

	s2d_ram #(
		.WIDTH(s2d_pkg::ENTRY_W),
		.DEPTH(s2d_pkg::STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q          <= s2d_pkg::RANK_W'(1);
			dim_size_q[0]   <= s2d_pkg::DIM_W'(1);
			dim_size_q[1]   <= s2d_pkg::DIM_W'(1);
			dim_size_q[2]   <= s2d_pkg::DIM_W'(1);
			dim_size_q[3]   <= s2d_pkg::DIM_W'(1);
			element_words_q <= s2d_pkg::DIM_W'(1);
			default_bits_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				s2d_pkg::CFG_RANK:          rank_q <= cfg_data[s2d_pkg::RANK_W-1:0];
				s2d_pkg::CFG_DIM_0:         dim_size_q[0] <= cfg_data[s2d_pkg::DIM_W-1:0];
				s2d_pkg::CFG_DIM_1:         dim_size_q[1] <= cfg_data[s2d_pkg::DIM_W-1:0];
				s2d_pkg::CFG_DIM_2:         dim_size_q[2] <= cfg_data[s2d_pkg::DIM_W-1:0];
				s2d_pkg::CFG_DIM_3:         dim_size_q[3] <= cfg_data[s2d_pkg::DIM_W-1:0];
				s2d_pkg::CFG_ELEMENT_WORDS: element_words_q <= cfg_data[s2d_pkg::DIM_W-1:0];
				s2d_pkg::CFG_DEFAULT_BITS:  default_bits_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign accept     = req_valid && req_ready;
	assign can_emit   = !rsp_valid_q || rsp_ready;
	assign sweep_last = (sweep_q == s2d_pkg::ADDR_W'(s2d_pkg::STORE_DEPTH - 1));

	always_comb begin
		if (rank_q == '0) begin
			eff_rank = s2d_pkg::RANK_W'(1);
		end else if (rank_q > s2d_pkg::RANK_W'(s2d_pkg::RANK_LIMIT)) begin
			eff_rank = s2d_pkg::RANK_W'(s2d_pkg::RANK_LIMIT);
		end else begin
			eff_rank = rank_q;
		end
	end

	assign last_step = (s2d_pkg::RANK_W'(step_q) == eff_rank - s2d_pkg::RANK_W'(1));
	assign ew_eff    = (element_words_q == '0) ? s2d_pkg::DIM_W'(1) : element_words_q;

	// one row-major step: lin * dim + idx
	assign cur_idx = idx_q[step_q];
	assign cur_dim = dim_size_q[step_q];
	assign lin_ext = s2d_pkg::PROD_W'(lin_q);
	assign dim_ext = s2d_pkg::PROD_W'(cur_dim);
	assign idx_ext = s2d_pkg::PROD_W'(cur_idx);
	assign prod    = lin_ext * dim_ext + idx_ext;
	assign idx_bad = (s2d_pkg::DIM_W'(cur_idx) >= cur_dim);
	assign lin_big = (prod >= s2d_pkg::PROD_W'(s2d_pkg::STORE_DEPTH));

	// scale by element size and add the element offset
	assign ew_ext  = s2d_pkg::PROD_W'(ew_eff);
	assign ofs_ext = s2d_pkg::PROD_W'(offset_q);
	assign scaled  = lin_ext * ew_ext + ofs_ext;
	assign addr_ok = !bad_q && (scaled < s2d_pkg::PROD_W'(s2d_pkg::STORE_DEPTH));

	assign ofs_next = {1'b0, offset_q} + 1'b1;
	assign ofs_adv  = (s2d_pkg::DIM_W'(ofs_next) >= ew_eff || ofs_next[s2d_pkg::OFS_W]) ?
		'0 : ofs_next[s2d_pkg::OFS_W-1:0];

	assign rd_in_range = (32'(req.read_address) < s2d_pkg::STORE_DEPTH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			s2d_pkg::ST_IDLE: begin
				if (req_valid) begin
					case (req.kind)
						s2d_pkg::KIND_CLEAR: state_d = s2d_pkg::ST_CLEAR;
						s2d_pkg::KIND_WRITE: state_d = s2d_pkg::ST_INDEX;
						s2d_pkg::KIND_READ:  state_d = s2d_pkg::ST_READ;
						default:             state_d = s2d_pkg::ST_EMIT;
					endcase
				end
			end
			s2d_pkg::ST_CLEAR: begin
				if (sweep_last) begin
					state_d = init_q ? s2d_pkg::ST_IDLE : s2d_pkg::ST_EMIT;
				end
			end
			s2d_pkg::ST_INDEX: begin
				if (last_step) begin
					state_d = s2d_pkg::ST_SCALE;
				end
			end
			s2d_pkg::ST_SCALE: state_d = s2d_pkg::ST_EMIT;
			s2d_pkg::ST_READ:  state_d = s2d_pkg::ST_EMIT;
			s2d_pkg::ST_EMIT: begin
				if (can_emit) begin
					state_d = s2d_pkg::ST_IDLE;
				end
			end
			default: state_d = s2d_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		load_out  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = '0;
		ram_raddr = s2d_pkg::ADDR_W'(req.read_address);
		case (state_q)
			s2d_pkg::ST_IDLE:  req_ready = 1'b1;
			s2d_pkg::ST_CLEAR: ram_we = 1'b1;
			s2d_pkg::ST_SCALE: begin
				ram_we    = addr_ok;
				ram_waddr = scaled[s2d_pkg::ADDR_W-1:0];
				ram_wdata = {1'b1, value_q};
			end
			s2d_pkg::ST_EMIT:  load_out = can_emit;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= s2d_pkg::ST_CLEAR;
			init_q      <= 1'b1;
			sweep_q     <= '0;
			offset_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == s2d_pkg::ST_CLEAR) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
				if (sweep_last) begin
					init_q <= 1'b0;
				end
			end
			if (accept && req.kind == s2d_pkg::KIND_CLEAR) begin
				offset_q <= '0;
			end else if (state_q == s2d_pkg::ST_SCALE) begin
				offset_q <= ofs_adv;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q[0] <= req.index_0;
			idx_q[1] <= req.index_1;
			idx_q[2] <= req.index_2;
			idx_q[3] <= req.index_3;
			value_q  <= req.value_bits;
			step_q   <= '0;
			lin_q    <= '0;
			bad_q    <= 1'b0;
			case (req.kind)
				s2d_pkg::KIND_CLEAR: res_q <= '{data_bits: '0, cell_address: '0, in_range: 1'b1};
				s2d_pkg::KIND_READ:  res_q <= '{data_bits: '0, cell_address: req.read_address,
					in_range: rd_in_range};
				default:             res_q <= '0;
			endcase
		end
		if (state_q == s2d_pkg::ST_INDEX) begin
			step_q <= step_q + 1'b1;
			lin_q  <= prod[s2d_pkg::ADDR_W-1:0];
			if (idx_bad || lin_big) begin
				bad_q <= 1'b1;
			end
		end
		if (state_q == s2d_pkg::ST_SCALE) begin
			if (addr_ok) begin
				res_q <= '{data_bits: '0,
					cell_address: s2d_pkg::CELL_W'(scaled[s2d_pkg::ADDR_W-1:0]),
					in_range: 1'b1};
			end else begin
				res_q <= '0;
			end
		end
		if (state_q == s2d_pkg::ST_READ) begin
			if (!res_q.in_range) begin
				res_q.data_bits <= '0;
			end else if (ram_rdata[s2d_pkg::WORD_W]) begin
				res_q.data_bits <= ram_rdata[s2d_pkg::WORD_W-1:0];
			end else begin
				res_q.data_bits <= default_bits_q;
			end
		end
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_ram_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == s2d_pkg::ST_CLEAR || state_q == s2d_pkg::ST_SCALE))
		else $error("store written outside clear sweep or write step");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> !req_ready)
		else $error("request taken while previous request in flight");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(state_q) == s2d_pkg::ST_EMIT))
		else $error("response raised outside emit state");

	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == s2d_pkg::ST_CLEAR && $past(state_q) != s2d_pkg::ST_CLEAR) |-> (sweep_q == '0))
		else $error("clear sweep does not start at entry zero");

endmodule
